[rtl/core/lscs_pkg.sv]
package lscs_pkg;

  localparam int unsigned MAX_SAMPLES     = 2048;
  localparam int unsigned SINE_TABLE_BITS = 10;

  localparam int unsigned IDX_W  = $clog2(MAX_SAMPLES);
  localparam int unsigned CNT_W  = IDX_W + 1;
  localparam int unsigned M2_W   = IDX_W + 1;
  localparam int unsigned A_W    = M2_W + 16;
  localparam int unsigned QSTEPS = 1 << SINE_TABLE_BITS;
  localparam int unsigned P_W    = SINE_TABLE_BITS + 2;
  localparam int unsigned K_W    = SINE_TABLE_BITS + 1;

  // phase = ((a + PH_BIAS) >> PH_SH) / 45, since a full circle is 45 * 2^20 units
  localparam int unsigned PH_SH   = 18 - SINE_TABLE_BITS;
  localparam int unsigned PH_BIAS = 45 << (PH_SH - 1);

  localparam int unsigned DIV_NW  = 32;
  localparam int unsigned MAGIC_W = 33;

  localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
  localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
  localparam logic [2:0]  LAST_TERM   = 3'd4;
  localparam logic [2:0]  DSEL_PHASE  = 3'd5;

  localparam logic [1:0] REG_RANGE_LIMIT = 2'd0;
  localparam logic [1:0] REG_X_OFFSET    = 2'd1;
  localparam logic [1:0] REG_ANGLE_STEP  = 2'd2;

  localparam logic [15:0] RST_RANGE_LIMIT = 16'd8000;
  localparam logic [15:0] RST_X_OFFSET    = 16'd450;
  localparam logic [15:0] RST_ANGLE_STEP  = 16'd32587;

  typedef struct packed {
    logic [15:0] range_limit_mm;
    logic [15:0] x_offset_mm;
    logic [15:0] angle_step;
  } cfg_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_RD0, ST_RD1, ST_MED, ST_MUL_A, ST_DIV_P, ST_WAIT_P, ST_SAVE_P,
    ST_MUL_K, ST_X, ST_MUL_X2, ST_X2, ST_MUL_T, ST_DIV_T, ST_WAIT_T, ST_SAVE_T,
    ST_MUL_XT, ST_MAG, ST_MUL_R, ST_SCALE, ST_OUT
  } state_e;

  typedef enum logic [4:0] {
    OP_NONE, OP_RD0, OP_RD1, OP_MED, OP_MUL_A, OP_DIV_P, OP_SAVE_P,
    OP_MUL_K, OP_X, OP_MUL_X2, OP_X2, OP_MUL_T, OP_DIV_T, OP_SAVE_T,
    OP_MUL_XT, OP_MAG, OP_MUL_R, OP_SCALE, OP_LOAD
  } op_e;

  typedef struct packed {
    op_e        op;
    logic       pass;
    logic [2:0] term;
  } cmd_t;

  typedef struct packed {
    logic close;
    logic div_done;
    logic out_free;
  } sts_t;

  typedef struct packed {
    logic [MAGIC_W-1:0] magic;
    logic [5:0]         shift;
  } recip_t;

  // exact floor division of a 32 bit value by a series divisor or by 45
  function automatic recip_t div_recip(input logic [2:0] dsel);
    recip_t r;
    unique case (dsel)
      3'd0:       r = '{magic: 33'd4997780127, shift: 6'd39};
      3'd1:       r = '{magic: 33'd7635497416, shift: 6'd39};
      3'd2:       r = '{magic: 33'd6544712071, shift: 6'd38};
      3'd3:       r = '{magic: 33'd6871947674, shift: 6'd37};
      LAST_TERM:  r = '{magic: 33'd5726623062, shift: 6'd35};
      DSEL_PHASE: r = '{magic: 33'd6108397933, shift: 6'd38};
      default:    r = '{magic: '0, shift: '0};
    endcase
    return r;
  endfunction

endpackage

[rtl/core/lscs_div.sv]
module lscs_div import lscs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DIV_NW-1:0] dividend_i,
  input  logic [2:0]        dsel_i,
  output logic              done_o,
  output logic [DIV_NW-1:0] quot_o
);

  logic                      step_q, done_q;
  logic [DIV_NW-1:0]         num_q;
  recip_t                    rcp_q;
  logic [DIV_NW+MAGIC_W-1:0] prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      step_q <= start_i;
      done_q <= step_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rcp_q <= div_recip(dsel_i);
    end
    if (step_q) begin
      prod_q <= (DIV_NW+MAGIC_W)'(num_q) * (DIV_NW+MAGIC_W)'(rcp_q.magic);
    end
  end

  assign done_o = done_q;
  assign quot_o = DIV_NW'(prod_q >> rcp_q.shift);

endmodule

[rtl/core/lscs_dp.sv]
module lscs_dp import lscs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  cmd_t               cmd_i,
  output sts_t               sts_o,
  input  logic               in_accept_i,
  input  logic [15:0]        range_mm_i,
  input  logic               is_infinite_i,
  input  logic               last_of_scan_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] cone_x_mm_o,
  output logic signed [16:0] cone_y_mm_o
);

  logic [IDX_W-1:0] idx_q, idx_d;
  logic             in_seg_q, in_seg_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [15:0]      min_q;
  logic [CNT_W-1:0] c_q;
  logic [15:0]      rmin_q;
  logic [15:0]      v;
  logic             below, close, wr_en;

  logic [IDX_W-1:0] mem [MAX_SAMPLES];
  logic [IDX_W-1:0] rdata_q, idx0_q, half, rd_addr;
  logic             rd_en;

  logic [M2_W-1:0]  m2_q;
  logic [63:0]      mul_q;
  logic [31:0]      mul_a, mul_b;
  logic             mul_en;
  logic [P_W-1:0]   p_q, pp;
  logic [K_W-1:0]   kk;
  logic [30:0]      x_q, t_q;
  logic [31:0]      x2_q;
  logic [16:0]      mag_q;
  logic [32:0]      tr, sr;
  logic signed [18:0] sv;
  logic [16:0]      sat;
  logic [16:0]      res_x_q, res_y_q;

  logic              div_start, div_done;
  logic [DIV_NW-1:0] div_n, quot;
  logic [2:0]        div_sel;
  logic [A_W:0]      a_bias;

  logic              out_valid_q;
  logic [16:0]       out_x_q, out_y_q;

  // segment tracking
  assign v     = is_infinite_i ? cfg_i.range_limit_mm : range_mm_i;
  assign below = v < cfg_i.range_limit_mm;
  assign close = (v == cfg_i.range_limit_mm) && in_seg_q;
  assign wr_en = in_accept_i && below && (cnt_q < CNT_W'(MAX_SAMPLES));

  always_comb begin
    idx_d    = idx_q;
    in_seg_d = in_seg_q;
    cnt_d    = cnt_q;
    if (in_accept_i) begin
      if (below) begin
        in_seg_d = 1'b1;
        if (wr_en) cnt_d = cnt_q + 1'b1;
      end else if (close) begin
        in_seg_d = 1'b0;
        cnt_d    = '0;
      end
      if (last_of_scan_i) begin
        idx_d    = '0;
        in_seg_d = 1'b0;
        cnt_d    = '0;
      end else if (idx_q == IDX_W'(MAX_SAMPLES - 1)) begin
        idx_d = '0;
      end else begin
        idx_d = idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q    <= '0;
      in_seg_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      idx_q    <= idx_d;
      in_seg_q <= in_seg_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept_i) begin
      if (below && (!in_seg_q || v < min_q)) min_q <= v;
      if (close) begin
        c_q    <= cnt_q;
        rmin_q <= min_q;
      end
    end
  end

  // index memory
  assign half    = c_q[CNT_W-1:1];
  assign rd_en   = (cmd_i.op == OP_RD0) || (cmd_i.op == OP_RD1);
  assign rd_addr = (cmd_i.op == OP_RD0 && !c_q[0]) ? half - 1'b1 : half;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[cnt_q[IDX_W-1:0]] <= idx_q;
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  // phase and quadrant
  assign pp = p_q + (cmd_i.pass ? P_W'(QSTEPS) : P_W'(0));
  assign kk = pp[P_W-2] ? K_W'(QSTEPS) - K_W'(pp[SINE_TABLE_BITS-1:0])
                        : K_W'(pp[SINE_TABLE_BITS-1:0]);

  // shared multiplier
  always_comb begin
    mul_en = 1'b1;
    mul_a  = '0;
    mul_b  = '0;
    unique case (cmd_i.op)
      OP_MUL_A: begin
        mul_a = 32'(m2_q);
        mul_b = 32'(cfg_i.angle_step);
      end
      OP_MUL_K: begin
        mul_a = 32'(kk);
        mul_b = 32'(HALF_PI_Q30);
      end
      OP_MUL_X2: begin
        mul_a = 32'(x_q);
        mul_b = 32'(x_q);
      end
      OP_MUL_T: begin
        mul_a = x2_q;
        mul_b = 32'(t_q);
      end
      OP_MUL_XT: begin
        mul_a = 32'(x_q);
        mul_b = 32'(t_q);
      end
      OP_MUL_R: begin
        mul_a = 32'(rmin_q);
        mul_b = 32'(mag_q);
      end
      default: mul_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mul_en) mul_q <= 64'(mul_a) * 64'(mul_b);
  end

  // constant divider
  assign a_bias    = {1'b0, mul_q[A_W-1:0]} + (A_W+1)'(PH_BIAS);
  assign div_start = (cmd_i.op == OP_DIV_P) || (cmd_i.op == OP_DIV_T);
  assign div_n     = (cmd_i.op == OP_DIV_P) ? DIV_NW'(a_bias >> PH_SH) : mul_q[61:30];
  assign div_sel   = (cmd_i.op == OP_DIV_P) ? DSEL_PHASE : cmd_i.term;

  lscs_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_n),
    .dsel_i     (div_sel),
    .done_o     (div_done),
    .quot_o     (quot)
  );

  // rounding and saturation
  assign tr = {1'b0, mul_q[61:30]} + 33'd8192;
  assign sr = mul_q[32:0] + 33'd32768;

  always_comb begin
    sv = pp[P_W-1] ? -$signed({2'b00, sr[32:16]}) : $signed({2'b00, sr[32:16]});
    if (!cmd_i.pass) sv = sv + $signed({{3{cfg_i.x_offset_mm[15]}}, cfg_i.x_offset_mm});
    if (sv > 19'sd65535)       sat = 17'h0FFFF;
    else if (sv < -19'sd65536) sat = 17'h10000;
    else                       sat = sv[16:0];
  end

  always_ff @(posedge clk_i) begin
    unique case (cmd_i.op)
      OP_RD1:    idx0_q <= rdata_q;
      OP_MED:    m2_q <= c_q[0] ? {idx0_q, 1'b0} : M2_W'(idx0_q) + M2_W'(rdata_q);
      OP_SAVE_P: p_q <= quot[P_W-1:0];
      OP_X:      x_q <= mul_q[SINE_TABLE_BITS +: 31];
      OP_X2: begin
        x2_q <= mul_q[61:30];
        t_q  <= ONE_Q30;
      end
      OP_SAVE_T: t_q <= ONE_Q30 - quot[30:0];
      OP_MAG:    mag_q <= tr[30:14];
      OP_SCALE: begin
        if (cmd_i.pass) res_y_q <= sat;
        else            res_x_q <= sat;
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.op == OP_LOAD) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.op == OP_LOAD) begin
      out_x_q <= res_x_q;
      out_y_q <= res_y_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign cone_x_mm_o = $signed(out_x_q);
  assign cone_y_mm_o = $signed(out_y_q);

  assign sts_o.close    = close;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

endmodule

[rtl/core/lscs_ctrl.sv]
module lscs_ctrl import lscs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_accept_i,
  input  sts_t sts_i,
  output cmd_t cmd_o,
  output logic in_ready_o
);

  state_e     state_q, state_d;
  logic       pass_q, pass_d;
  logic [2:0] term_q, term_d;

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    term_d  = term_q;
    unique case (state_q)
      ST_IDLE: begin
        pass_d = 1'b0;
        if (in_accept_i && sts_i.close) state_d = ST_RD0;
      end
      ST_RD0:    state_d = ST_RD1;
      ST_RD1:    state_d = ST_MED;
      ST_MED:    state_d = ST_MUL_A;
      ST_MUL_A:  state_d = ST_DIV_P;
      ST_DIV_P:  state_d = ST_WAIT_P;
      ST_WAIT_P: if (sts_i.div_done) state_d = ST_SAVE_P;
      ST_SAVE_P: state_d = ST_MUL_K;
      ST_MUL_K:  state_d = ST_X;
      ST_X:      state_d = ST_MUL_X2;
      ST_MUL_X2: state_d = ST_X2;
      ST_X2: begin
        term_d  = '0;
        state_d = ST_MUL_T;
      end
      ST_MUL_T:  state_d = ST_DIV_T;
      ST_DIV_T:  state_d = ST_WAIT_T;
      ST_WAIT_T: if (sts_i.div_done) state_d = ST_SAVE_T;
      ST_SAVE_T: begin
        if (term_q == LAST_TERM) begin
          state_d = ST_MUL_XT;
        end else begin
          term_d  = term_q + 1'b1;
          state_d = ST_MUL_T;
        end
      end
      ST_MUL_XT: state_d = ST_MAG;
      ST_MAG:    state_d = ST_MUL_R;
      ST_MUL_R:  state_d = ST_SCALE;
      ST_SCALE: begin
        if (pass_q) begin
          state_d = ST_OUT;
        end else begin
          pass_d  = 1'b1;
          state_d = ST_MUL_K;
        end
      end
      ST_OUT:    if (sts_i.out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o.pass = pass_q;
    cmd_o.term = term_q;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.op   = OP_NONE;
        in_ready_o = 1'b1;
      end
      ST_RD0:    cmd_o.op = OP_RD0;
      ST_RD1:    cmd_o.op = OP_RD1;
      ST_MED:    cmd_o.op = OP_MED;
      ST_MUL_A:  cmd_o.op = OP_MUL_A;
      ST_DIV_P:  cmd_o.op = OP_DIV_P;
      ST_SAVE_P: cmd_o.op = OP_SAVE_P;
      ST_MUL_K:  cmd_o.op = OP_MUL_K;
      ST_X:      cmd_o.op = OP_X;
      ST_MUL_X2: cmd_o.op = OP_MUL_X2;
      ST_X2:     cmd_o.op = OP_X2;
      ST_MUL_T:  cmd_o.op = OP_MUL_T;
      ST_DIV_T:  cmd_o.op = OP_DIV_T;
      ST_SAVE_T: cmd_o.op = OP_SAVE_T;
      ST_MUL_XT: cmd_o.op = OP_MUL_XT;
      ST_MAG:    cmd_o.op = OP_MAG;
      ST_MUL_R:  cmd_o.op = OP_MUL_R;
      ST_SCALE:  cmd_o.op = OP_SCALE;
      ST_OUT:    cmd_o.op = sts_i.out_free ? OP_LOAD : OP_NONE;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pass_q  <= 1'b0;
      term_q  <= '0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      term_q  <= term_d;
    end
  end

  a_close_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept_i && sts_i.close |=> state_q == ST_RD0)
    else $error("closing item did not start cone work");

  a_div_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts_i.div_done |-> (state_q == ST_WAIT_P || state_q == ST_WAIT_T))
    else $error("divider finished outside a wait state");

  a_term_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    term_q <= LAST_TERM)
    else $error("series term count out of range");

endmodule

[rtl/core/lidar_scan_cone_segmenter.sv]
// a sample that closes no segment is taken at once, and such samples are taken every cycle while idle
// a closing sample drops the input ready while the cone is worked: median read, phase, two sine series
// the cone enters the output register from the output state, once the output register is free
// the next sample is taken after the cone has entered the output register, later while a cone still waits
// reset is asynchronous active low; it clears the segment state and loads register defaults
module lidar_scan_cone_segmenter import lscs_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [15:0]        range_mm_i,
  input  logic               is_infinite_i,
  input  logic               last_of_scan_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [16:0] cone_x_mm_o,
  output logic signed [16:0] cone_y_mm_o
);

  cfg_t cfg_q;
  cmd_t cmd;
  sts_t sts;
  logic in_accept, wr;

  assign pready    = 1'b1;
  assign wr        = psel && penable && pwrite;
  assign in_accept = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.range_limit_mm <= RST_RANGE_LIMIT;
      cfg_q.x_offset_mm    <= RST_X_OFFSET;
      cfg_q.angle_step     <= RST_ANGLE_STEP;
    end else if (wr) begin
      case (paddr[3:2])
        REG_RANGE_LIMIT: cfg_q.range_limit_mm <= pwdata[15:0];
        REG_X_OFFSET:    cfg_q.x_offset_mm    <= pwdata[15:0];
        REG_ANGLE_STEP:  cfg_q.angle_step     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_RANGE_LIMIT: prdata = 32'(cfg_q.range_limit_mm);
      REG_X_OFFSET:    prdata = {{16{cfg_q.x_offset_mm[15]}}, cfg_q.x_offset_mm};
      REG_ANGLE_STEP:  prdata = 32'(cfg_q.angle_step);
      default:         prdata = '0;
    endcase
  end

  lscs_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_accept_i (in_accept),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready_o)
  );

  lscs_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .in_accept_i    (in_accept),
    .range_mm_i     (range_mm_i),
    .is_infinite_i  (is_infinite_i),
    .last_of_scan_i (last_of_scan_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cone_x_mm_o    (cone_x_mm_o),
    .cone_y_mm_o    (cone_y_mm_o)
  );

endmodule
